[sv/lse_pkg.sv]
// Shared types and constants of the Lindbladian element engine.
// Depends on nothing; lse_cmac and the top level import it.
package lse_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int MAX_OPS_DEF = 8;

  localparam int VAL_W  = 32;
  localparam int ELEM_W = 48;
  localparam int PROD_W = 64;
  localparam int RND_W  = 40;
  localparam int TERM_W = 41;
  localparam int ACC_W  = 56;

  localparam logic signed [VAL_W-1:0] ONE_Q   = 32'sh0100_0000;
  localparam logic signed [ACC_W-1:0] SAT_HI  = 56'sh007FFF_FFFFFFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO  = 56'shFF8000_00000000;

  localparam logic [1:0] REQ_HAM  = 2'd0;
  localparam logic [1:0] REQ_OP   = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic REG_DIM = 1'b0;
  localparam logic REG_OPS = 1'b1;

  localparam logic [3:0] DIM_RST = 4'd2;
  localparam logic [3:0] OPS_RST = 4'd0;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [2:0]              op_index;
    logic [5:0]              row_index;
    logic [5:0]              col_index;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
  } lse_in_t;

  typedef struct packed {
    logic                     status;
    logic signed [ELEM_W-1:0] elem_re;
    logic signed [ELEM_W-1:0] elem_im;
  } lse_out_t;

  typedef enum logic [2:0] {
    TK_H1,
    TK_H2,
    TK_X,
    TK_L1,
    TK_L2
  } term_kind_t;

  typedef struct packed {
    logic       vld;
    logic       clr;
    term_kind_t kind;
  } term_ctl_t;

endpackage

[sv/lse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lse_cmac.sv]
// Shared complex multiply-accumulate unit: four products, rounding, signed accumulate.
// Depends on lse_pkg.
module lse_cmac
  import lse_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  term_ctl_t                ctl,
  input  logic signed [VAL_W-1:0]  a_re,
  input  logic signed [VAL_W-1:0]  a_im,
  input  logic signed [VAL_W-1:0]  b_re,
  input  logic signed [VAL_W-1:0]  b_im,
  output logic                     busy,
  output logic signed [ACC_W-1:0]  acc_re,
  output logic signed [ACC_W-1:0]  acc_im
);

  localparam logic signed [PROD_W-1:0] HALF = 64'sh0000_0000_0080_0000;

  function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + HALF;
    return RND_W'(t >>> 24);
  endfunction

  logic                     s2_vld_r, s3_vld_r;
  term_kind_t               s2_kind_r, s3_kind_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [PROD_W-1:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;
  logic signed [TERM_W-1:0] s3_re_r, s3_im_r, s3_re_nxt, s3_im_nxt;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic signed [ACC_W-1:0]  xr, xi;

  assign p1_nxt = a_re * b_re;
  assign p2_nxt = a_im * b_im;
  assign p3_nxt = a_re * b_im;
  assign p4_nxt = a_im * b_re;

  assign s3_re_nxt = TERM_W'(rnd(p1_r)) + TERM_W'(rnd(p2_r));
  assign s3_im_nxt = TERM_W'(rnd(p4_r)) - TERM_W'(rnd(p3_r));

  assign xr = ACC_W'(s3_re_r);
  assign xi = ACC_W'(s3_im_r);

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (ctl.clr) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (s3_vld_r) begin
      case (s3_kind_r)
        TK_X: begin
          acc_re_nxt = acc_re_r + (xr <<< 1);
          acc_im_nxt = acc_im_r + (xi <<< 1);
        end
        TK_L1: begin
          acc_re_nxt = acc_re_r - xr;
          acc_im_nxt = acc_im_r + xi;
        end
        TK_L2: begin
          acc_re_nxt = acc_re_r - xr;
          acc_im_nxt = acc_im_r - xi;
        end
        TK_H1: begin
          acc_re_nxt = acc_re_r + (xi <<< 1);
          acc_im_nxt = acc_im_r - (xr <<< 1);
        end
        TK_H2: begin
          acc_re_nxt = acc_re_r + (xi <<< 1);
          acc_im_nxt = acc_im_r + (xr <<< 1);
        end
        default: begin
          acc_re_nxt = acc_re_r;
          acc_im_nxt = acc_im_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else begin
      s2_vld_r <= ctl.vld;
      s3_vld_r <= s2_vld_r;
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
    s2_kind_r <= ctl.kind;
    s3_kind_r <= s2_kind_r;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    p3_r      <= p3_nxt;
    p4_r      <= p4_nxt;
    s3_re_r   <= s3_re_nxt;
    s3_im_r   <= s3_im_nxt;
  end

  assign busy   = s2_vld_r | s3_vld_r;
  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

[sv/lindbladian_superoperator_element.sv]
// Top level of the Lindbladian element engine: register port, stores, sequencer.
// Depends on lse_pkg, lse_ram and lse_cmac.
//
// Loads, rejected requests and unknown request types are answered from the idle
// state: the result is registered and the next transfer is taken in the following
// cycle if out_ready frees the result register. A read first divides the row and
// column index by the dimension d, then issues the two Hamiltonian terms and, for
// each of the n operators, a cross term and two sums over m; the first sum runs over
// all d values when the column digits of row and column match (else one) and the
// second when the row digits match. The single complex multiply-accumulate unit
// takes one term per cycle; the two stores are read once per term, the operator
// store through two copies so that both factors of a product arrive together.
// Input is not taken during a read. Loads must precede the reads that use them.
module lindbladian_superoperator_element
  import lse_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int MAX_OPS = MAX_OPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  lse_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lse_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW  = $clog2(MAX_DIM);
  localparam int MAT = MAX_DIM * MAX_DIM;
  localparam int HAW = $clog2(MAT);
  localparam int OPN = MAX_OPS * MAT;
  localparam int OAW = $clog2(OPN);
  localparam int KW  = $clog2(MAX_OPS + 1);
  localparam int KIW = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ISSUE, ST_DRAIN, ST_DONE} state_t;
  typedef enum logic [2:0] {PH_H1, PH_H2, PH_X, PH_L1, PH_L2} phase_t;

  function automatic logic [HAW-1:0] haddr(input logic [DW-1:0] i, input logic [DW-1:0] j);
    return HAW'(int'(i) * MAX_DIM + int'(j));
  endfunction

  function automatic logic [OAW-1:0] oaddr(input logic [KIW-1:0] k, input logic [DW-1:0] i,
                                           input logic [DW-1:0] j);
    return OAW'(int'(k) * MAT + int'(i) * MAX_DIM + int'(j));
  endfunction

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [3:0]      dim_r, ops_r;
  logic [5:0]      rrem_r, crem_r, rrem_nxt, crem_nxt;
  logic [DW-1:0]   ia_r, ja_r, ia_nxt, ja_nxt, m_r, m_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  term_ctl_t       s1_ctl_r, iss;
  logic            out_valid_r, out_valid_nxt;
  lse_out_t        out_data_r, out_data_nxt;

  logic [4:0]      d5, n5;
  logic [9:0]      dsq;
  logic [KW-1:0]   nops;
  logic [DW-1:0]   ib, jb, dlast;
  logic            dij, dab, m_end, k_end;
  logic            acc_in, load_ok, read_ok, cfg_wr;

  logic            ham_we, op_we;
  logic [HAW-1:0]  ham_waddr, ham_raddr;
  logic [OAW-1:0]  op_waddr, opa_raddr, opb_raddr;
  logic [63:0]     wword, ham_rd, opa_rd, opb_rd;

  logic signed [VAL_W-1:0] a_re, a_im, b_re, b_im;
  logic signed [ACC_W-1:0] acc_re, acc_im, fin_re, fin_im;
  logic                    cmac_busy;

  // effective dimension and operator count
  always_comb begin
    if (dim_r == 4'd0) begin
      d5 = 5'd1;
    end else if ({1'b0, dim_r} > 5'(MAX_DIM)) begin
      d5 = 5'(MAX_DIM);
    end else begin
      d5 = {1'b0, dim_r};
    end
    if ({1'b0, ops_r} > 5'(MAX_OPS)) begin
      n5 = 5'(MAX_OPS);
    end else begin
      n5 = {1'b0, ops_r};
    end
  end

  assign nops  = n5[KW-1:0];
  assign dsq   = 10'(d5) * 10'(d5);
  assign dlast = DW'(d5 - 5'd1);
  assign ib    = rrem_r[DW-1:0];
  assign jb    = crem_r[DW-1:0];
  assign dij   = (ib == jb);
  assign dab   = (ia_r == ja_r);
  assign m_end = (m_r == dlast);
  assign k_end = ((k_r + KW'(1)) == nops);

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc_in   = in_valid && in_ready;

  assign load_ok = ({1'b0, in_data.row_index} < {2'b0, d5}) &&
                   ({1'b0, in_data.col_index} < {2'b0, d5}) &&
                   ((in_data.req_type == REQ_HAM) ||
                    ((in_data.req_type == REQ_OP) && (5'(in_data.op_index) < 5'(MAX_OPS))));
  assign read_ok = (in_data.req_type == REQ_READ) &&
                   (10'(in_data.row_index) < dsq) && (10'(in_data.col_index) < dsq);

  assign wword     = {in_data.value_im, in_data.value_re};
  assign ham_we    = acc_in && load_ok && (in_data.req_type == REQ_HAM);
  assign op_we     = acc_in && load_ok && (in_data.req_type == REQ_OP);
  assign ham_waddr = haddr(in_data.row_index[DW-1:0], in_data.col_index[DW-1:0]);
  assign op_waddr  = oaddr(KIW'(in_data.op_index), in_data.row_index[DW-1:0],
                           in_data.col_index[DW-1:0]);

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {28'd0, (paddr[2] == REG_OPS) ? ops_r : dim_r};

  // finish: halve with rounding, saturate
  always_comb begin
    fin_re = (acc_re + ACC_W'(1)) >>> 1;
    fin_im = (acc_im + ACC_W'(1)) >>> 1;
    if (fin_re > SAT_HI) fin_re = SAT_HI;
    if (fin_re < SAT_LO) fin_re = SAT_LO;
    if (fin_im > SAT_HI) fin_im = SAT_HI;
    if (fin_im < SAT_LO) fin_im = SAT_LO;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rrem_nxt      = rrem_r;
    crem_nxt      = crem_r;
    ia_nxt        = ia_r;
    ja_nxt        = ja_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    iss           = '{vld: 1'b0, clr: 1'b0, kind: TK_X};
    ham_raddr     = haddr(ia_r, ja_r);
    opa_raddr     = oaddr(k_r[KIW-1:0], ia_r, ja_r);
    opb_raddr     = oaddr(k_r[KIW-1:0], ib, jb);

    unique case (state_r)
      ST_IDLE: begin
        if (acc_in) begin
          if (read_ok) begin
            rrem_nxt  = in_data.row_index;
            crem_nxt  = in_data.col_index;
            ia_nxt    = '0;
            ja_nxt    = '0;
            state_nxt = ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: load_ok ? STATUS_OK : STATUS_ERR,
                              elem_re: '0, elem_im: '0};
          end
        end
      end
      ST_DIV: begin
        if (rrem_r >= 6'(d5)) begin
          rrem_nxt = rrem_r - 6'(d5);
          ia_nxt   = ia_r + DW'(1);
        end
        if (crem_r >= 6'(d5)) begin
          crem_nxt = crem_r - 6'(d5);
          ja_nxt   = ja_r + DW'(1);
        end
        if ((rrem_r < 6'(d5)) && (crem_r < 6'(d5))) begin
          iss.clr   = 1'b1;
          phase_nxt = PH_H1;
          k_nxt     = '0;
          m_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        unique case (phase_r)
          PH_H1: begin
            iss.vld   = dij;
            iss.kind  = TK_H1;
            ham_raddr = haddr(ia_r, ja_r);
            phase_nxt = PH_H2;
          end
          PH_H2: begin
            iss.vld   = dab;
            iss.kind  = TK_H2;
            ham_raddr = haddr(ib, jb);
            phase_nxt = PH_X;
            if (nops == '0) begin
              state_nxt = ST_DRAIN;
            end
          end
          PH_X: begin
            iss.vld   = 1'b1;
            iss.kind  = TK_X;
            opa_raddr = oaddr(k_r[KIW-1:0], ia_r, ja_r);
            opb_raddr = oaddr(k_r[KIW-1:0], ib, jb);
            m_nxt     = '0;
            phase_nxt = PH_L1;
          end
          PH_L1: begin
            iss.vld   = dij;
            iss.kind  = TK_L1;
            opa_raddr = oaddr(k_r[KIW-1:0], m_r, ia_r);
            opb_raddr = oaddr(k_r[KIW-1:0], m_r, ja_r);
            if (!dij || m_end) begin
              m_nxt     = '0;
              phase_nxt = PH_L2;
            end else begin
              m_nxt = m_r + DW'(1);
            end
          end
          PH_L2: begin
            iss.vld   = dab;
            iss.kind  = TK_L2;
            opa_raddr = oaddr(k_r[KIW-1:0], m_r, ib);
            opb_raddr = oaddr(k_r[KIW-1:0], m_r, jb);
            if (!dab || m_end) begin
              m_nxt     = '0;
              k_nxt     = k_r + KW'(1);
              phase_nxt = PH_X;
              if (k_end) begin
                state_nxt = ST_DRAIN;
              end
            end else begin
              m_nxt = m_r + DW'(1);
            end
          end
          default: phase_nxt = PH_H1;
        endcase
      end
      ST_DRAIN: begin
        if (!s1_ctl_r.vld && !cmac_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: STATUS_OK, elem_re: ELEM_W'(fin_re),
                            elem_im: ELEM_W'(fin_im)};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_H1;
      dim_r       <= DIM_RST;
      ops_r       <= OPS_RST;
      out_valid_r <= 1'b0;
      s1_ctl_r    <= '{vld: 1'b0, clr: 1'b0, kind: TK_X};
      k_r         <= '0;
      m_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      s1_ctl_r    <= iss;
      k_r         <= k_nxt;
      m_r         <= m_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_DIM) begin
          dim_r <= pwdata[3:0];
        end else begin
          ops_r <= pwdata[3:0];
        end
      end
    end
    rrem_r     <= rrem_nxt;
    crem_r     <= crem_nxt;
    ia_r       <= ia_nxt;
    ja_r       <= ja_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lse_ram #(.WIDTH(64), .DEPTH(MAT)) u_ham (
    .clk(clk), .we(ham_we), .waddr(ham_waddr), .wdata(wword),
    .raddr(ham_raddr), .rdata(ham_rd)
  );

  lse_ram #(.WIDTH(64), .DEPTH(OPN)) u_opa (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(wword),
    .raddr(opa_raddr), .rdata(opa_rd)
  );

  lse_ram #(.WIDTH(64), .DEPTH(OPN)) u_opb (
    .clk(clk), .we(op_we), .waddr(op_waddr), .wdata(wword),
    .raddr(opb_raddr), .rdata(opb_rd)
  );

  // Hamiltonian terms multiply by one
  always_comb begin
    if ((s1_ctl_r.kind == TK_H1) || (s1_ctl_r.kind == TK_H2)) begin
      a_re = ham_rd[31:0];
      a_im = ham_rd[63:32];
      b_re = ONE_Q;
      b_im = '0;
    end else begin
      a_re = opa_rd[31:0];
      a_im = opa_rd[63:32];
      b_re = opb_rd[31:0];
      b_im = opb_rd[63:32];
    end
  end

  lse_cmac u_cmac (
    .clk(clk), .rst_n(rst_n), .ctl(s1_ctl_r),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .busy(cmac_busy), .acc_re(acc_re), .acc_im(acc_im)
  );

  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken during a read");

  a_no_issue_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !iss.vld)
    else $error("term issued before indices are known");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid_r || out_ready))
    else $error("transfer accepted with result register occupied");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!cmac_busy && !s1_ctl_r.vld))
    else $error("result taken before accumulation finished");

endmodule
